// File: hdl/stunbr_pkg.sv
// Shared types and constants for the binding response parser.
package stunbr_pkg;

   localparam int unsigned DATAGRAM_BYTES = 512;

   localparam logic [31:0] MAGIC_COOKIE       = 32'h2112A442;
   localparam logic [15:0] ATTR_XOR_MAPPED    = 16'h0020;
   localparam logic [15:0] MAX_MESSAGE_LENGTH = 16'd548;
   localparam logic [10:0] MIN_DATAGRAM       = 11'd24;
   localparam logic [10:0] DATAGRAM_LIMIT     = 11'(DATAGRAM_BYTES);
   localparam logic [9:0]  HEADER_BYTES       = 10'd20;
   localparam logic [9:0]  POSITION_MAX       = 10'd1023;
   localparam logic [7:0]  MESSAGE_TYPE_BYTE  = 8'h01;
   localparam logic [15:0] FAMILY_IPV4        = 16'h0001;
   localparam logic [15:0] MIN_MAPPED_LENGTH  = 16'd8;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_BAD_LENGTH   = 3'd1;
   localparam logic [2:0] STATUS_BAD_TYPE     = 3'd2;
   localparam logic [2:0] STATUS_BAD_COOKIE   = 3'd3;
   localparam logic [2:0] STATUS_ID_MISMATCH  = 3'd4;
   localparam logic [2:0] STATUS_INCONSISTENT = 3'd5;
   localparam logic [2:0] STATUS_NO_ADDRESS   = 3'd6;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TXN_UPPER = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TXN_LOWER = 2'd1;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_VALUE,
      PHASE_PAD
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic        mapped_found;
      logic [2:0]  parse_status;
      logic [31:0] mapped_address;
      logic [15:0] mapped_port;
   } rsp_item_type;

endpackage

// File: hdl/stunbr_input_stage.sv
// Input register that holds one datagram byte item for the parse core.
module stunbr_input_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  stunbr_pkg::req_item_type req_item,
   input  logic                    proceed,
   output logic                    hold_valid,
   output stunbr_pkg::req_item_type hold_item
);
   import stunbr_pkg::*;

   logic         hold_valid_ff;
   logic         hold_valid_in;
   req_item_type hold_item_ff;
   logic         accept;

   assign req_stall = hold_valid_ff && !proceed;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (proceed) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_item_ff <= req_item;
      end
   end

   assign hold_valid = hold_valid_ff;
   assign hold_item  = hold_item_ff;

endmodule

// File: hdl/stunbr_parse_core.sv
// Header checks, attribute walk, address capture and status; one byte per cycle while proceed is high.
module stunbr_parse_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [stunbr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [63:0]                         csr_data,
   input  logic                                proceed,
   input  stunbr_pkg::req_item_type            item,
   output logic                                fire,
   output stunbr_pkg::rsp_item_type            result
);
   import stunbr_pkg::*;

   logic [31:0]  txn_upper_ff;
   logic [63:0]  txn_lower_ff;

   logic [9:0]   byte_position_ff,    byte_position_in;
   logic [15:0]  message_length_ff,   message_length_in;
   logic [2:0]   header_fault_ff,     header_fault_in;
   phase_type    phase_ff,            phase_in;
   logic [15:0]  attribute_type_ff,   attribute_type_in;
   logic [15:0]  attribute_length_ff, attribute_length_in;
   logic [9:0]   attribute_offset_ff, attribute_offset_in;
   logic         walk_stopped_ff,     walk_stopped_in;
   logic         address_captured_ff, address_captured_in;
   logic [31:0]  captured_address_ff, captured_address_in;
   logic [15:0]  captured_port_ff,    captured_port_in;

   logic [127:0] header_ref;
   logic [3:0]   header_index;
   logic [7:0]   want_byte;
   logic [7:0]   b;
   logic [9:0]   p;
   logic [16:0]  end_pos;
   logic [9:0]   offset_next;
   logic [1:0]   pad;
   logic [15:0]  port_new;
   logic         mapped_attr;
   logic         offset_hold;
   logic [10:0]  total;
   logic [2:0]   status;

   assign header_ref   = {MAGIC_COOKIE, txn_upper_ff, txn_lower_ff};
   assign b            = item.data_byte;
   assign p            = byte_position_ff;
   assign header_index = 4'(HEADER_BYTES - 10'd1 - p);
   assign want_byte    = header_ref[{header_index, 3'b000} +: 8];
   assign end_pos      = 17'(HEADER_BYTES) + 17'(message_length_ff);
   assign offset_next  = attribute_offset_ff + 10'd1;
   assign pad          = 2'd0 - attribute_length_ff[1:0];
   assign mapped_attr  = (attribute_type_ff == ATTR_XOR_MAPPED)
                         && (attribute_length_ff >= MIN_MAPPED_LENGTH);

   always_comb begin
      byte_position_in    = byte_position_ff;
      message_length_in   = message_length_ff;
      header_fault_in     = header_fault_ff;
      phase_in            = phase_ff;
      attribute_type_in   = attribute_type_ff;
      attribute_length_in = attribute_length_ff;
      attribute_offset_in = attribute_offset_ff;
      walk_stopped_in     = walk_stopped_ff;
      address_captured_in = address_captured_ff;
      captured_address_in = captured_address_ff;
      captured_port_in    = captured_port_ff;
      port_new            = {captured_port_ff[15:8], b};
      offset_hold         = 1'b0;
      total               = 11'(p) + 11'd1;
      status              = STATUS_OK;
      fire                = 1'b0;

      if (proceed) begin
         if (p < HEADER_BYTES) begin
            priority if (p <= 10'd1) begin
               if ((b != MESSAGE_TYPE_BYTE) && (header_fault_ff == STATUS_OK)) begin
                  header_fault_in = STATUS_BAD_TYPE;
               end
            end else if (p == 10'd2) begin
               message_length_in = {b, 8'h00};
            end else if (p == 10'd3) begin
               message_length_in = {message_length_ff[15:8], b};
            end else if (p <= 10'd7) begin
               if ((b != want_byte) && (header_fault_ff == STATUS_OK)) begin
                  header_fault_in = STATUS_BAD_COOKIE;
               end
            end else begin
               if ((b != want_byte) && (header_fault_ff == STATUS_OK)) begin
                  header_fault_in = STATUS_ID_MISMATCH;
               end
            end
         end else if ((message_length_ff <= MAX_MESSAGE_LENGTH) && !walk_stopped_ff
                      && (17'(p) < end_pos)) begin
            unique case (phase_ff)
               PHASE_HEADER: begin
                  unique case (attribute_offset_ff[1:0])
                     2'd0: attribute_type_in   = {b, 8'h00};
                     2'd1: attribute_type_in   = {attribute_type_ff[15:8], b};
                     2'd2: attribute_length_in = {b, 8'h00};
                     default: attribute_length_in = {attribute_length_ff[15:8], b};
                  endcase
                  if (attribute_offset_ff < 10'd3) begin
                     attribute_offset_in = offset_next;
                  end else begin
                     attribute_offset_in = '0;
                     if (17'(p) + 17'd1 + 17'(attribute_length_in) > end_pos) begin
                        walk_stopped_in = 1'b1;
                     end else if (attribute_length_in != 16'd0) begin
                        phase_in = PHASE_VALUE;
                     end
                  end
               end
               PHASE_VALUE: begin
                  if (mapped_attr) begin
                     unique case (attribute_offset_ff)
                        10'd0: captured_port_in = {b, 8'h00};
                        10'd1: begin
                           captured_port_in = port_new;
                           if (port_new != FAMILY_IPV4) begin
                              attribute_type_in = '0;
                           end
                        end
                        10'd2: captured_port_in = {b, 8'h00};
                        10'd3: captured_port_in = port_new;
                        10'd4: captured_address_in = {24'h000000, b};
                        10'd5, 10'd6: captured_address_in = {captured_address_ff[23:0], b};
                        10'd7: begin
                           captured_address_in = {captured_address_ff[23:0], b};
                           address_captured_in = 1'b1;
                           walk_stopped_in     = 1'b1;
                           offset_hold         = 1'b1;
                        end
                        default: ;
                     endcase
                  end
                  if (!offset_hold) begin
                     if (16'(offset_next) >= attribute_length_ff) begin
                        attribute_offset_in = '0;
                        phase_in = (pad != 2'd0) ? PHASE_PAD : PHASE_HEADER;
                     end else begin
                        attribute_offset_in = offset_next;
                     end
                  end
               end
               PHASE_PAD: begin
                  if (offset_next >= 10'(pad)) begin
                     attribute_offset_in = '0;
                     phase_in = PHASE_HEADER;
                  end else begin
                     attribute_offset_in = offset_next;
                  end
               end
               default: begin
                  attribute_offset_in = '0;
                  phase_in = PHASE_HEADER;
               end
            endcase
         end

         if (item.last_byte) begin
            fire = 1'b1;
            priority if ((total < MIN_DATAGRAM) || (total >= DATAGRAM_LIMIT)) begin
               status = STATUS_BAD_LENGTH;
            end else if (header_fault_in != STATUS_OK) begin
               status = header_fault_in;
            end else if ((message_length_in > MAX_MESSAGE_LENGTH)
                         || (17'(HEADER_BYTES) + 17'(message_length_in) > 17'(total))) begin
               status = STATUS_INCONSISTENT;
            end else if (!address_captured_in) begin
               status = STATUS_NO_ADDRESS;
            end else begin
               status = STATUS_OK;
            end
         end
      end

      result.mapped_found   = (status == STATUS_OK);
      result.parse_status   = status;
      result.mapped_address = (status == STATUS_OK) ? (captured_address_in ^ MAGIC_COOKIE)
                                                    : 32'h00000000;
      result.mapped_port    = (status == STATUS_OK) ? (captured_port_in ^ MAGIC_COOKIE[31:16])
                                                    : 16'h0000;

      if (proceed) begin
         if (item.last_byte) begin
            byte_position_in    = '0;
            message_length_in   = '0;
            header_fault_in     = STATUS_OK;
            phase_in            = PHASE_HEADER;
            attribute_type_in   = '0;
            attribute_length_in = '0;
            attribute_offset_in = '0;
            walk_stopped_in     = 1'b0;
            address_captured_in = 1'b0;
            captured_address_in = '0;
            captured_port_in    = '0;
         end else if (p < POSITION_MAX) begin
            byte_position_in = p + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         txn_upper_ff <= '0;
         txn_lower_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_TXN_UPPER) begin
            txn_upper_ff <= csr_data[31:0];
         end else if (csr_index == CSR_TXN_LOWER) begin
            txn_lower_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff    <= '0;
         message_length_ff   <= '0;
         header_fault_ff     <= STATUS_OK;
         phase_ff            <= PHASE_HEADER;
         attribute_type_ff   <= '0;
         attribute_length_ff <= '0;
         attribute_offset_ff <= '0;
         walk_stopped_ff     <= 1'b0;
         address_captured_ff <= 1'b0;
         captured_address_ff <= '0;
         captured_port_ff    <= '0;
      end else begin
         byte_position_ff    <= byte_position_in;
         message_length_ff   <= message_length_in;
         header_fault_ff     <= header_fault_in;
         phase_ff            <= phase_in;
         attribute_type_ff   <= attribute_type_in;
         attribute_length_ff <= attribute_length_in;
         attribute_offset_ff <= attribute_offset_in;
         walk_stopped_ff     <= walk_stopped_in;
         address_captured_ff <= address_captured_in;
         captured_address_ff <= captured_address_in;
         captured_port_ff    <= captured_port_in;
      end
   end

endmodule

// File: hdl/stunbr_output_stage.sv
// Result register that holds one status item until the receiver takes it.
module stunbr_output_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  stunbr_pkg::rsp_item_type load_item,
   output logic                    busy,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output stunbr_pkg::rsp_item_type rsp_item
);
   import stunbr_pkg::*;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_item_ff;

   assign busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff <= load_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: hdl/stun_binding_response_parser.sv
// Top level: input register, parse core and result register.
// A result item is registered as its last byte item leaves the input register.
// Throughput: one byte item per cycle; only a last byte item waits, in the input
// register, while the result register is full and stalled.
// Reset: synchronous, active high; clears the parse state and the transaction ID
// registers and empties both item registers.
module stun_binding_response_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  stunbr_pkg::req_item_type            req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output stunbr_pkg::rsp_item_type            rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [stunbr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [63:0]                         csr_data
);
   import stunbr_pkg::*;

   logic         hold_valid;
   req_item_type hold_item;
   logic         proceed;
   logic         out_busy;
   logic         fire;
   rsp_item_type result;

   assign csr_ready = 1'b1;
   assign proceed   = hold_valid && (!hold_item.last_byte || !out_busy);

   stunbr_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .proceed    (proceed),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   stunbr_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .proceed   (proceed),
      .item      (hold_item),
      .fire      (fire),
      .result    (result)
   );

   stunbr_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .load_item (result),
      .busy      (out_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
